// File: sv/scc_pkg.sv
// shared types and constants for the sector cache tag and replacement block
package scc_pkg;

  localparam int SLOT_W   = 6;
  localparam int SECTOR_W = 32;

  // command codes
  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // one request transfer
  typedef struct packed {
    logic                cmd;
    logic [SECTOR_W-1:0] sector;
    logic                mark_dirty;
  } req_t;

  // one result transfer
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                hit;
    logic                fill_needed;
    logic                writeback_valid;
    logic [SECTOR_W-1:0] writeback_sector;
    logic [SLOT_W-1:0]   writeback_slot;
    logic                last;
  } rsp_t;

endpackage

// File: sv/sector_cache_clock_tags_top.sv
// sector cache tag lookup and second-chance clock replacement, top level
//
// Usage: a request (req) is taken when start is high and busy is low. An
// access looks the sector up in the tag ram, one slot per cycle, through a
// single shared tag comparator. A hit answers as soon as its slot has been
// compared; a miss that finds a free slot ends after the full scan. With
// no free slot the clock hand sweeps one slot per cycle until it finds a
// clear accessed bit (at most CACHE_SLOTS + 1 steps), then reads the victim
// tag and answers. A flush scans every slot the same way and emits one
// writeback transfer per dirty slot, in slot order, the last of them in the
// final transfer (alone if no slot is dirty), and frees every slot.
// The scan length is set by the single read port of the tag ram.
// Each result is on rsp for one cycle with rsp_valid high; last marks the
// final result of a request. The receiver cannot stall, so no result waits.
// busy is high from the accepted request until the final result is on rsp;
// it is low in that cycle, so a new request can be taken at its end. Reset
// frees every slot, sets all accessed bits, clears dirty bits and the hand;
// tag ram contents are left as they are and read only for valid slots.
module sector_cache_clock_tags_top #(
  parameter int CACHE_SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  scc_pkg::req_t req,
  output scc_pkg::rsp_t rsp,
  output logic          rsp_valid
);

  import scc_pkg::*;

  localparam int IDX_W = $clog2(CACHE_SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_SLOTS - 1);
  localparam logic [CNT_W-1:0] NUM_SLOTS = CNT_W'(CACHE_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SWEEP,
    ST_EVICT,
    ST_FLUSH_END
  } state_t;

  state_t state, state_next;

  logic [CNT_W-1:0]       issue_cnt, issue_cnt_next;
  logic                   rd_vld, rd_vld_next;
  logic [IDX_W-1:0]       rd_idx, rd_idx_next;
  logic                   free_found, free_found_next;
  logic [IDX_W-1:0]       free_idx, free_idx_next;
  logic [IDX_W-1:0]       hand, hand_next;
  logic [IDX_W-1:0]       ptr, ptr_next;
  logic [CACHE_SLOTS-1:0] valid, valid_next;
  logic [CACHE_SLOTS-1:0] acc, acc_next;
  logic [CACHE_SLOTS-1:0] dirty, dirty_next;
  logic                   pend_vld, pend_vld_next;
  logic [SECTOR_W-1:0]    pend_tag, pend_tag_next;
  logic [IDX_W-1:0]       pend_slot, pend_slot_next;
  req_t                   req_q, req_q_next;
  rsp_t                   rsp_next;
  logic                   rsp_valid_next;

  // tag ram ports
  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [IDX_W-1:0]       ram_raddr;
  logic [SECTOR_W-1:0]    ram_rdata;

  logic                   tag_match;

  scc_ram #(
    .WIDTH (SECTOR_W),
    .DEPTH (CACHE_SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_q.sector),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    next_idx = (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  // shared tag comparator
  assign tag_match = valid[rd_idx] && (ram_rdata == req_q.sector);

  assign busy = (state != ST_IDLE);

  // sequencer
  always_comb begin
    state_next      = state;
    issue_cnt_next  = issue_cnt;
    rd_vld_next     = 1'b0;
    rd_idx_next     = rd_idx;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    hand_next       = hand;
    ptr_next        = ptr;
    valid_next      = valid;
    acc_next        = acc;
    dirty_next      = dirty;
    pend_vld_next   = pend_vld;
    pend_tag_next   = pend_tag;
    pend_slot_next  = pend_slot;
    req_q_next      = req_q;
    rsp_next        = '0;
    rsp_valid_next  = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = ptr;
    ram_raddr       = '0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          req_q_next      = req;
          issue_cnt_next  = '0;
          free_found_next = 1'b0;
          pend_vld_next   = 1'b0;
          state_next      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue one tag read per cycle
        ram_raddr = issue_cnt[IDX_W-1:0];
        if (issue_cnt < NUM_SLOTS) begin
          rd_vld_next    = 1'b1;
          rd_idx_next    = issue_cnt[IDX_W-1:0];
          issue_cnt_next = issue_cnt + 1'b1;
        end
        // look at the tag read last cycle
        if (rd_vld) begin
          if (req_q.cmd == CMD_FLUSH) begin
            if (valid[rd_idx] && dirty[rd_idx]) begin
              if (pend_vld) begin
                rsp_valid_next                = 1'b1;
                rsp_next.writeback_valid      = 1'b1;
                rsp_next.writeback_sector     = pend_tag;
                rsp_next.writeback_slot       = SLOT_W'(pend_slot);
              end
              pend_vld_next  = 1'b1;
              pend_tag_next  = ram_rdata;
              pend_slot_next = rd_idx;
            end
            if (rd_idx == LAST_IDX) begin
              state_next = ST_FLUSH_END;
            end
          end else if (tag_match) begin
            acc_next[rd_idx]   = 1'b1;
            dirty_next[rd_idx] = dirty[rd_idx] | req_q.mark_dirty;
            rsp_valid_next     = 1'b1;
            rsp_next.slot      = SLOT_W'(rd_idx);
            rsp_next.hit       = 1'b1;
            rsp_next.last      = 1'b1;
            state_next         = ST_IDLE;
          end else begin
            if (!valid[rd_idx] && !free_found) begin
              free_found_next = 1'b1;
              free_idx_next   = rd_idx;
            end
            if (rd_idx == LAST_IDX) begin
              state_next = ST_DECIDE;
            end
          end
        end
      end

      ST_DECIDE: begin
        if (free_found) begin
          ram_we               = 1'b1;
          ram_waddr            = free_idx;
          valid_next[free_idx] = 1'b1;
          dirty_next[free_idx] = req_q.mark_dirty;
          rsp_valid_next       = 1'b1;
          rsp_next.slot        = SLOT_W'(free_idx);
          rsp_next.fill_needed = 1'b1;
          rsp_next.last        = 1'b1;
          state_next           = ST_IDLE;
        end else begin
          ptr_next   = hand;
          state_next = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        // one clock step per cycle
        ram_raddr = ptr;
        if (!acc[ptr]) begin
          state_next = ST_EVICT;
        end else begin
          acc_next[ptr] = 1'b0;
          ptr_next      = next_idx(ptr);
        end
      end

      ST_EVICT: begin
        ram_we          = 1'b1;
        ram_waddr       = ptr;
        acc_next[ptr]   = 1'b1;
        dirty_next[ptr] = req_q.mark_dirty;
        hand_next       = next_idx(ptr);
        rsp_valid_next       = 1'b1;
        rsp_next.slot        = SLOT_W'(ptr);
        rsp_next.fill_needed = 1'b1;
        rsp_next.last        = 1'b1;
        if (dirty[ptr]) begin
          rsp_next.writeback_valid  = 1'b1;
          rsp_next.writeback_sector = ram_rdata;
          rsp_next.writeback_slot   = SLOT_W'(ptr);
        end
        state_next = ST_IDLE;
      end

      ST_FLUSH_END: begin
        rsp_valid_next = 1'b1;
        rsp_next.last  = 1'b1;
        if (pend_vld) begin
          rsp_next.writeback_valid  = 1'b1;
          rsp_next.writeback_sector = pend_tag;
          rsp_next.writeback_slot   = SLOT_W'(pend_slot);
        end
        valid_next    = '0;
        acc_next      = '1;
        dirty_next    = '0;
        hand_next     = '0;
        pend_vld_next = 1'b0;
        state_next    = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue_cnt  <= '0;
      rd_vld     <= 1'b0;
      free_found <= 1'b0;
      hand       <= '0;
      valid      <= '0;
      acc        <= '1;
      dirty      <= '0;
      pend_vld   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      issue_cnt  <= issue_cnt_next;
      rd_vld     <= rd_vld_next;
      free_found <= free_found_next;
      hand       <= hand_next;
      valid      <= valid_next;
      acc        <= acc_next;
      dirty      <= dirty_next;
      pend_vld   <= pend_vld_next;
      rsp_valid  <= rsp_valid_next;
    end
    rd_idx    <= rd_idx_next;
    free_idx  <= free_idx_next;
    ptr       <= ptr_next;
    pend_tag  <= pend_tag_next;
    pend_slot <= pend_slot_next;
    req_q     <= req_q_next;
    rsp       <= rsp_next;
  end

`ifndef SYNTHESIS
  // the final result of a request frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.last |-> !busy)
    else $error("final result while still busy");

  // an accepted request makes the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // a hit never asks for a fill or a writeback
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> !rsp.fill_needed && !rsp.writeback_valid)
    else $error("hit result with fill or writeback");

  // the clock hand stays inside the slot range
  a_hand_range: assert property (@(posedge clk) disable iff (rst)
    hand <= LAST_IDX)
    else $error("clock hand out of range");
`endif

endmodule

// File: sv/scc_ram.sv
// generic single write port, single read port ram with registered read
module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: verif/tb_sector_cache_clock_tags_top.sv
// testbench for the sector cache tag lookup and clock replacement block
`timescale 1ns / 1ps

module tb_sector_cache_clock_tags_top;
  import scc_pkg::*;

  localparam int SLOTS       = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_RANDOM    = 130;
  localparam int POOL_N      = 96;
  localparam int HOT_N       = 12;

  typedef struct {
    req_t req;
    int   reps;
    bit   typed;
    rsp_t exp;
  } row_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  rsp_t rsp;
  logic rsp_valid;

  // shadow copy of the tag and replacement state
  logic [SECTOR_W-1:0] shadow_tag[SLOTS];
  bit                  shadow_valid[SLOTS];
  bit                  shadow_accessed[SLOTS];
  bit                  shadow_dirty[SLOTS];
  int                  shadow_hand;

  rsp_t   step_rsps[$];
  rsp_t   pending_rsps[$];
  row_t   dir_rows[$];
  int     mismatches;
  int     cycles;
  logic [SECTOR_W-1:0] sector_pool[POOL_N];

  sector_cache_clock_tags_top #(
    .CACHE_SLOTS(SLOTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .rsp      (rsp),
    .rsp_valid(rsp_valid)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // all slots free, accessed bits set, hand at zero
  function automatic void shadow_clear();
    for (int i = 0; i < SLOTS; i++) begin
      shadow_tag[i]      = '0;
      shadow_valid[i]    = 1'b0;
      shadow_accessed[i] = 1'b1;
      shadow_dirty[i]    = 1'b0;
    end
    shadow_hand = 0;
  endfunction

  // work out the results of one request and update the shadow state
  function automatic void cache_step(input req_t r);
    rsp_t o;
    int   p;
    step_rsps.delete();
    // flush: one writeback per dirty slot in slot order, then free everything
    if (r.cmd == CMD_FLUSH) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_valid[i] && shadow_dirty[i]) begin
          o = '0;
          o.writeback_valid  = 1'b1;
          o.writeback_sector = shadow_tag[i];
          o.writeback_slot   = SLOT_W'(i);
          step_rsps.push_back(o);
        end
      end
      if (step_rsps.size() == 0) begin
        o = '0;
        o.last = 1'b1;
        step_rsps.push_back(o);
      end else begin
        step_rsps[step_rsps.size()-1].last = 1'b1;
      end
      shadow_clear();
      return;
    end
    // lookup among valid slots
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_valid[i] && shadow_tag[i] == r.sector) begin
        shadow_accessed[i] = 1'b1;
        shadow_dirty[i]    = shadow_dirty[i] | r.mark_dirty;
        o = '0;
        o.slot = SLOT_W'(i);
        o.hit  = 1'b1;
        o.last = 1'b1;
        step_rsps.push_back(o);
        return;
      end
    end
    // miss into the lowest free slot, accessed bit untouched
    for (int i = 0; i < SLOTS; i++) begin
      if (!shadow_valid[i]) begin
        shadow_valid[i] = 1'b1;
        shadow_tag[i]   = r.sector;
        shadow_dirty[i] = r.mark_dirty;
        o = '0;
        o.slot        = SLOT_W'(i);
        o.fill_needed = 1'b1;
        o.last        = 1'b1;
        step_rsps.push_back(o);
        return;
      end
    end
    // second-chance sweep from the hand
    p = shadow_hand % SLOTS;
    for (int s = 0; s <= SLOTS; s++) begin
      if (!shadow_accessed[p]) begin
        o = '0;
        o.slot        = SLOT_W'(p);
        o.fill_needed = 1'b1;
        o.last        = 1'b1;
        if (shadow_dirty[p]) begin
          o.writeback_valid  = 1'b1;
          o.writeback_sector = shadow_tag[p];
          o.writeback_slot   = SLOT_W'(p);
        end
        shadow_accessed[p] = 1'b1;
        shadow_tag[p]      = r.sector;
        shadow_dirty[p]    = r.mark_dirty;
        shadow_hand        = (p + 1) % SLOTS;
        step_rsps.push_back(o);
        return;
      end
      shadow_accessed[p] = 1'b0;
      p = (p + 1) % SLOTS;
    end
  endfunction

  // one directed row; typed rows carry a single result known up front
  function automatic void add_row(input logic cmd, input logic [SECTOR_W-1:0] sector,
                                  input logic mark_dirty, input int reps, input bit typed,
                                  input int slot, input logic hit, input logic fill);
    row_t row;
    row.req.cmd        = cmd;
    row.req.sector     = sector;
    row.req.mark_dirty = mark_dirty;
    row.reps           = reps;
    row.typed          = typed;
    row.exp            = '0;
    row.exp.slot        = SLOT_W'(slot);
    row.exp.hit         = hit;
    row.exp.fill_needed = fill;
    row.exp.last        = 1'b1;
    dir_rows.push_back(row);
  endfunction

  // present one request, optionally after an idle gap, and wait until it is taken
  task automatic issue(input req_t r, input bit typed, input rsp_t exp, input int idle_pct);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (!(start && !busy));
    cache_step(r);
    if (typed) pending_rsps.push_back(exp);
    else foreach (step_rsps[i]) pending_rsps.push_back(step_rsps[i]);
  endtask

  function automatic void check_field(input string name, input logic [31:0] e,
                                      input logic [31:0] g);
    if (g !== e) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, e, g);
    end
  endfunction

  // result checker: every result strobe must match the oldest expectation
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid === 1'b1) begin
      if (pending_rsps.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result %h", $time, rsp);
      end else begin
        e = pending_rsps.pop_front();
        check_field("slot", 32'(e.slot), 32'(rsp.slot));
        check_field("hit", 32'(e.hit), 32'(rsp.hit));
        check_field("fill_needed", 32'(e.fill_needed), 32'(rsp.fill_needed));
        check_field("writeback_valid", 32'(e.writeback_valid),
                    32'(rsp.writeback_valid));
        check_field("writeback_sector", e.writeback_sector, rsp.writeback_sector);
        check_field("writeback_slot", 32'(e.writeback_slot), 32'(rsp.writeback_slot));
        check_field("last", 32'(e.last), 32'(rsp.last));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sector_cache_clock_tags_top: done, errors");
      $finish;
    end
  end

  initial begin
    req_t r;
    rsp_t none;
    int   idle_pct;
    int   pick;
    mismatches = 0;
    cycles     = 0;
    none       = '0;
    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    shadow_clear();

    // directed rows
    add_row(CMD_FLUSH, 32'h0, 1'b0, 1, 1, 0, 1'b0, 1'b0);           // flush on empty cache
    add_row(CMD_ACCESS, 32'h0, 1'b0, 1, 1, 0, 1'b0, 1'b1);          // free-slot miss
    add_row(CMD_ACCESS, 32'hFFFF_FFFF, 1'b1, 1, 1, 1, 1'b0, 1'b1);  // free-slot miss, dirty
    add_row(CMD_ACCESS, 32'h0, 1'b1, 1, 1, 0, 1'b1, 1'b0);          // hit marks dirty
    add_row(CMD_ACCESS, 32'hFFFF_FFFF, 1'b0, 1, 1, 1, 1'b1, 1'b0);  // hit keeps dirty
    add_row(CMD_FLUSH, 32'hAAAA_5555, 1'b1, 1, 0, 0, 1'b0, 1'b0);   // two writebacks
    add_row(CMD_FLUSH, 32'h5555_AAAA, 1'b0, 1, 1, 0, 1'b0, 1'b0);   // nothing left dirty
    add_row(CMD_ACCESS, 32'h0000_2000, 1'b0, SLOTS, 0, 0, 1'b0, 1'b0); // fill every slot
    add_row(CMD_ACCESS, 32'h0000_2000, 1'b1, 1, 1, 0, 1'b1, 1'b0);  // dirty slot 0 by hit
    add_row(CMD_ACCESS, 32'h5555_AAAA, 1'b0, 1, 0, 0, 1'b0, 1'b0);  // full turn, dirty victim
    add_row(CMD_ACCESS, 32'h0000_3000, 1'b1, 1, 0, 0, 1'b0, 1'b0);  // clean victim
    add_row(CMD_ACCESS, 32'h0000_2002, 1'b0, 1, 1, 2, 1'b1, 1'b0);  // second chance for slot 2
    add_row(CMD_ACCESS, 32'h0000_3001, 1'b1, 1, 0, 0, 1'b0, 1'b0);  // sweep skips slot 2
    add_row(CMD_ACCESS, 32'h0000_3000, 1'b0, 1, 1, 1, 1'b1, 1'b0);  // hit on refilled slot
    add_row(CMD_FLUSH, 32'h0, 1'b0, 1, 0, 0, 1'b0, 1'b0);           // writebacks after evictions
    add_row(CMD_ACCESS, 32'h8000_0001, 1'b0, 1, 1, 0, 1'b0, 1'b1);  // slot 0 free again
    add_row(CMD_FLUSH, 32'hFFFF_FFFF, 1'b1, 1, 1, 0, 1'b0, 1'b0);   // clean slot only

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        r = dir_rows[i].req;
        r.sector = r.sector + SECTOR_W'(k);
        issue(r, dir_rows[i].typed, dir_rows[i].exp, 0);
      end
    end

    // random part: a working set larger than the cache, with a hot subset
    for (int i = 0; i < POOL_N; i++) sector_pool[i] = $urandom();
    for (int n = 0; n < N_RANDOM; n++) begin
      case (n * 3 / N_RANDOM)
        0:       idle_pct = 0;
        1:       idle_pct = 74;
        default: idle_pct = 6;
      endcase
      r.cmd        = CMD_ACCESS;
      r.mark_dirty = 1'($urandom_range(0, 1));
      pick         = $urandom_range(0, 99);
      if ($urandom_range(0, 79) == 0) begin
        r.cmd    = CMD_FLUSH;
        r.sector = $urandom();
      end else if (pick < 10) begin
        r.sector = $urandom();
      end else if (pick < 50) begin
        r.sector = sector_pool[$urandom_range(0, HOT_N - 1)];
      end else begin
        r.sector = sector_pool[$urandom_range(0, POOL_N - 1)];
      end
      issue(r, 1'b0, none, idle_pct);
    end
    start <= 1'b0;

    // drain, then a quiet stretch to catch stray results
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (2 * SLOTS + 10) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_sector_cache_clock_tags_top: done, clean");
    end else begin
      $display("tb_sector_cache_clock_tags_top: done, errors");
    end
    $finish;
  end

endmodule
